### src/tmp_pkg.sv
// Shared types and constants of the transaction message parser.
package tmp_pkg;

	localparam int unsigned STORED_ACCOUNTS = 16;
	localparam int unsigned MAX_COUNT_BYTES = 3;

	localparam logic [8:0]  STORED_LIMIT = 9'(STORED_ACCOUNTS);
	localparam logic [1:0]  COUNT_LAST_POS = 2'(MAX_COUNT_BYTES - 1);
	localparam logic [7:0]  VERSION_MARK = 8'h80;
	localparam logic [15:0] SIG_BYTES = 16'd64;
	localparam logic [15:0] KEY_BYTES = 16'd32;

	localparam logic [4:0] SEC_SIGCNT   = 5'd0;
	localparam logic [4:0] SEC_SIG      = 5'd1;
	localparam logic [4:0] SEC_VERSION  = 5'd2;
	localparam logic [4:0] SEC_HDR0     = 5'd3;
	localparam logic [4:0] SEC_HDR1     = 5'd4;
	localparam logic [4:0] SEC_HDR2     = 5'd5;
	localparam logic [4:0] SEC_ACCTCNT  = 5'd6;
	localparam logic [4:0] SEC_KEY      = 5'd7;
	localparam logic [4:0] SEC_HASH     = 5'd8;
	localparam logic [4:0] SEC_INSTRCNT = 5'd9;
	localparam logic [4:0] SEC_PROG     = 5'd10;
	localparam logic [4:0] SEC_IDXCNT   = 5'd11;
	localparam logic [4:0] SEC_IDX      = 5'd12;
	localparam logic [4:0] SEC_DLEN     = 5'd13;
	localparam logic [4:0] SEC_DATA     = 5'd14;
	localparam logic [4:0] SEC_ALTCNT   = 5'd15;
	localparam logic [4:0] SEC_ALTKEY   = 5'd16;
	localparam logic [4:0] SEC_WCNT     = 5'd17;
	localparam logic [4:0] SEC_WIDX     = 5'd18;
	localparam logic [4:0] SEC_RCNT     = 5'd19;
	localparam logic [4:0] SEC_RIDX     = 5'd20;
	localparam logic [4:0] SEC_TRAIL    = 5'd21;
	localparam logic [4:0] SEC_REJECT   = 5'd22;

	localparam logic [1:0] ST_BUSY   = 2'd0;
	localparam logic [1:0] ST_ACCEPT = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	localparam logic [1:0] PREF_NONE    = 2'd0;
	localparam logic [1:0] PREF_STORED  = 2'd1;
	localparam logic [1:0] PREF_UNKNOWN = 2'd2;

	typedef enum logic [22:0] {
		PH_SIGCNT   = 23'h000001,
		PH_SIG      = 23'h000002,
		PH_VERHDR   = 23'h000004,
		PH_HDR0     = 23'h000008,
		PH_HDR1     = 23'h000010,
		PH_HDR2     = 23'h000020,
		PH_ACCTCNT  = 23'h000040,
		PH_KEY      = 23'h000080,
		PH_HASH     = 23'h000100,
		PH_INSTRCNT = 23'h000200,
		PH_PROG     = 23'h000400,
		PH_IDXCNT   = 23'h000800,
		PH_IDX      = 23'h001000,
		PH_DLEN     = 23'h002000,
		PH_DATA     = 23'h004000,
		PH_ALTCNT   = 23'h008000,
		PH_ALTKEY   = 23'h010000,
		PH_WCNT     = 23'h020000,
		PH_WIDX     = 23'h040000,
		PH_RCNT     = 23'h080000,
		PH_RIDX     = 23'h100000,
		PH_TRAIL    = 23'h200000,
		PH_REJ      = 23'h400000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  section;
		logic [15:0] item_index;
		logic [15:0] byte_offset;
		logic [15:0] count_value;
		logic        count_done;
		logic [1:0]  program_ref;
		logic        versioned;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic [15:0] merged;
		logic        done;
		logic        overflow;
	} vint_t;

endpackage

### src/tmp_stream_if.sv
// Valid/ready stream interface that carries one payload beat per handshake.
interface tmp_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### src/tmp_varint.sv
// Compact count decoder: merges one varint byte into the running value.
module tmp_varint (
	input  logic [15:0]   accum,
	input  logic [1:0]    count_pos,
	input  logic [7:0]    data,
	output tmp_pkg::vint_t vint
);
	import tmp_pkg::*;

	logic [15:0] part;

	always_comb begin
		case (count_pos)
			2'd0: part = {9'd0, data[6:0]};
			2'd1: part = {2'd0, data[6:0], 7'd0};
			default: part = {data[1:0], 14'd0};
		endcase
	end

	assign vint.merged   = accum | part;
	assign vint.done     = ~data[7];
	assign vint.overflow = data[7] & (count_pos >= COUNT_LAST_POS);

endmodule

### src/tmp_core.sv
// Parser state machine: tags one byte per step and updates the parse state.
module tmp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  tmp_pkg::in_item_t   item,
	output tmp_pkg::out_item_t  res
);
	import tmp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] accum_q, accum_d;
	logic [1:0]  cbytes_q, cbytes_d;
	logic        vflag_q, vflag_d;
	logic [15:0] total_q, total_d;
	logic [15:0] outer_left_q, outer_left_d;
	logic [15:0] inner_left_q, inner_left_d;
	logic [15:0] outer_idx_q, outer_idx_d;
	logic [15:0] byte_idx_q, byte_idx_d;
	logic        rejected_q, rejected_d;

	vint_t       vint;
	logic        bad;
	logic        ol_last;
	logic        il_last;
	logic [15:0] ol_dec;
	logic [15:0] oi_inc;
	logic [15:0] il_dec;
	logic [15:0] bi_inc;
	logic [15:0] byte_wide;
	phase_t      instr_end;

	tmp_varint u_varint (
		.accum    (accum_q),
		.count_pos(cbytes_q),
		.data     (item.data_byte),
		.vint     (vint)
	);

	assign ol_last   = (outer_left_q == 16'd1);
	assign il_last   = (inner_left_q == 16'd1);
	assign ol_dec    = outer_left_q - 16'd1;
	assign oi_inc    = outer_idx_q + 16'd1;
	assign il_dec    = inner_left_q - 16'd1;
	assign bi_inc    = byte_idx_q + 16'd1;
	assign byte_wide = {8'd0, item.data_byte};
	assign instr_end = vflag_q ? PH_ALTCNT : PH_TRAIL;

	always_comb begin
		phase_d      = phase_q;
		accum_d      = accum_q;
		cbytes_d     = cbytes_q;
		vflag_d      = vflag_q;
		total_d      = total_q;
		outer_left_d = outer_left_q;
		inner_left_d = inner_left_q;
		outer_idx_d  = outer_idx_q;
		byte_idx_d   = byte_idx_q;
		rejected_d   = rejected_q;
		bad          = 1'b0;
		res          = '0;
		res.section  = SEC_REJECT;

		case (phase_q)
			PH_SIGCNT, PH_ACCTCNT, PH_INSTRCNT, PH_IDXCNT,
			PH_DLEN, PH_ALTCNT, PH_WCNT, PH_RCNT: begin
				res.byte_offset = {14'd0, cbytes_q};
				if (vint.overflow) begin
					bad      = 1'b1;
					accum_d  = '0;
					cbytes_d = '0;
				end else if (vint.done) begin
					accum_d         = '0;
					cbytes_d        = '0;
					res.count_done  = 1'b1;
					res.count_value = vint.merged;
				end else begin
					accum_d  = vint.merged;
					cbytes_d = cbytes_q + 2'd1;
				end
				case (phase_q)
					PH_SIGCNT: begin
						res.section = SEC_SIGCNT;
						if (vint.done) begin
							outer_idx_d = '0;
							byte_idx_d  = '0;
							if (vint.merged == 16'd0) begin
								phase_d = PH_VERHDR;
							end else begin
								outer_left_d = vint.merged;
								inner_left_d = SIG_BYTES;
								phase_d      = PH_SIG;
							end
						end
					end
					PH_ACCTCNT: begin
						res.section = SEC_ACCTCNT;
						if (vint.done) begin
							total_d      = vint.merged;
							outer_idx_d  = '0;
							byte_idx_d   = '0;
							inner_left_d = KEY_BYTES;
							if (vint.merged == 16'd0) begin
								phase_d = PH_HASH;
							end else begin
								outer_left_d = vint.merged;
								phase_d      = PH_KEY;
							end
						end
					end
					PH_INSTRCNT: begin
						res.section = SEC_INSTRCNT;
						if (vint.done) begin
							outer_idx_d = '0;
							if (vint.merged == 16'd0) begin
								phase_d = instr_end;
							end else begin
								outer_left_d = vint.merged;
								phase_d      = PH_PROG;
							end
						end
					end
					PH_IDXCNT: begin
						res.section    = SEC_IDXCNT;
						res.item_index = outer_idx_q;
						if (vint.done) begin
							byte_idx_d = '0;
							if (vint.merged == 16'd0) begin
								phase_d = PH_DLEN;
							end else begin
								inner_left_d = vint.merged;
								phase_d      = PH_IDX;
							end
						end
					end
					PH_DLEN: begin
						res.section    = SEC_DLEN;
						res.item_index = outer_idx_q;
						if (vint.done) begin
							byte_idx_d = '0;
							if (vint.merged == 16'd0) begin
								outer_idx_d  = oi_inc;
								outer_left_d = ol_dec;
								if (ol_last) begin
									phase_d = instr_end;
								end else begin
									phase_d      = PH_PROG;
									inner_left_d = KEY_BYTES;
								end
							end else begin
								inner_left_d = vint.merged;
								phase_d      = PH_DATA;
							end
						end
					end
					PH_ALTCNT: begin
						res.section = SEC_ALTCNT;
						if (vint.done) begin
							outer_idx_d = '0;
							byte_idx_d  = '0;
							if (vint.merged == 16'd0) begin
								phase_d = PH_TRAIL;
							end else begin
								outer_left_d = vint.merged;
								inner_left_d = KEY_BYTES;
								phase_d      = PH_ALTKEY;
							end
						end
					end
					PH_WCNT: begin
						res.section    = SEC_WCNT;
						res.item_index = outer_idx_q;
						if (vint.done) begin
							byte_idx_d = '0;
							if (vint.merged == 16'd0) begin
								phase_d = PH_RCNT;
							end else begin
								inner_left_d = vint.merged;
								phase_d      = PH_WIDX;
							end
						end
					end
					default: begin
						res.section    = SEC_RCNT;
						res.item_index = outer_idx_q;
						if (vint.done) begin
							byte_idx_d = '0;
							if (vint.merged == 16'd0) begin
								outer_idx_d  = oi_inc;
								outer_left_d = ol_dec;
								if (ol_last) begin
									phase_d = PH_TRAIL;
								end else begin
									phase_d      = PH_ALTKEY;
									inner_left_d = KEY_BYTES;
								end
							end else begin
								inner_left_d = vint.merged;
								phase_d      = PH_RIDX;
							end
						end
					end
				endcase
			end
			PH_SIG: begin
				res.section     = SEC_SIG;
				res.item_index  = outer_idx_q;
				res.byte_offset = byte_idx_q;
				byte_idx_d      = bi_inc;
				inner_left_d    = il_dec;
				if (il_last) begin
					outer_idx_d  = oi_inc;
					outer_left_d = ol_dec;
					byte_idx_d   = '0;
					if (ol_last) begin
						phase_d = PH_VERHDR;
					end else begin
						phase_d      = PH_SIG;
						inner_left_d = SIG_BYTES;
					end
				end
			end
			PH_VERHDR: begin
				if (item.data_byte == VERSION_MARK) begin
					res.section = SEC_VERSION;
					vflag_d     = 1'b1;
					phase_d     = PH_HDR0;
				end else begin
					res.section = SEC_HDR0;
					phase_d     = PH_HDR1;
				end
			end
			PH_HDR0: begin
				res.section = SEC_HDR0;
				phase_d     = PH_HDR1;
			end
			PH_HDR1: begin
				res.section     = SEC_HDR1;
				res.byte_offset = 16'd1;
				phase_d         = PH_HDR2;
			end
			PH_HDR2: begin
				res.section     = SEC_HDR2;
				res.byte_offset = 16'd2;
				phase_d         = PH_ACCTCNT;
			end
			PH_KEY: begin
				res.section     = SEC_KEY;
				res.item_index  = outer_idx_q;
				res.byte_offset = byte_idx_q;
				byte_idx_d      = bi_inc;
				inner_left_d    = il_dec;
				if (il_last) begin
					outer_idx_d  = oi_inc;
					outer_left_d = ol_dec;
					byte_idx_d   = '0;
					inner_left_d = KEY_BYTES;
					phase_d      = ol_last ? PH_HASH : PH_KEY;
				end
			end
			PH_HASH: begin
				res.section     = SEC_HASH;
				res.byte_offset = byte_idx_q;
				byte_idx_d      = bi_inc;
				inner_left_d    = il_dec;
				if (il_last) begin
					phase_d = PH_INSTRCNT;
				end
			end
			PH_PROG: begin
				res.section    = SEC_PROG;
				res.item_index = outer_idx_q;
				if (({1'b0, item.data_byte} < STORED_LIMIT) && (byte_wide < total_q)) begin
					res.program_ref = PREF_STORED;
				end else if ((byte_wide < total_q) || vflag_q) begin
					res.program_ref = PREF_UNKNOWN;
				end else begin
					bad = 1'b1;
				end
				phase_d = PH_IDXCNT;
			end
			PH_IDX: begin
				res.section     = SEC_IDX;
				res.item_index  = outer_idx_q;
				res.byte_offset = byte_idx_q;
				byte_idx_d      = bi_inc;
				inner_left_d    = il_dec;
				if (il_last) begin
					phase_d = PH_DLEN;
				end
			end
			PH_DATA: begin
				res.section     = SEC_DATA;
				res.item_index  = outer_idx_q;
				res.byte_offset = byte_idx_q;
				byte_idx_d      = bi_inc;
				inner_left_d    = il_dec;
				if (il_last) begin
					outer_idx_d  = oi_inc;
					outer_left_d = ol_dec;
					byte_idx_d   = '0;
					if (ol_last) begin
						phase_d = instr_end;
					end else begin
						phase_d      = PH_PROG;
						inner_left_d = KEY_BYTES;
					end
				end
			end
			PH_ALTKEY: begin
				res.section     = SEC_ALTKEY;
				res.item_index  = outer_idx_q;
				res.byte_offset = byte_idx_q;
				byte_idx_d      = bi_inc;
				inner_left_d    = il_dec;
				if (il_last) begin
					phase_d = PH_WCNT;
				end
			end
			PH_WIDX: begin
				res.section     = SEC_WIDX;
				res.item_index  = outer_idx_q;
				res.byte_offset = byte_idx_q;
				byte_idx_d      = bi_inc;
				inner_left_d    = il_dec;
				if (il_last) begin
					phase_d = PH_RCNT;
				end
			end
			PH_RIDX: begin
				res.section     = SEC_RIDX;
				res.item_index  = outer_idx_q;
				res.byte_offset = byte_idx_q;
				byte_idx_d      = bi_inc;
				inner_left_d    = il_dec;
				if (il_last) begin
					outer_idx_d  = oi_inc;
					outer_left_d = ol_dec;
					byte_idx_d   = '0;
					if (ol_last) begin
						phase_d = PH_TRAIL;
					end else begin
						phase_d      = PH_ALTKEY;
						inner_left_d = KEY_BYTES;
					end
				end
			end
			PH_TRAIL: begin
				res.section = SEC_TRAIL;
			end
			default: begin
				res.section = SEC_REJECT;
				bad         = 1'b1;
			end
		endcase

		if (bad) begin
			phase_d    = PH_REJ;
			rejected_d = 1'b1;
		end

		res.versioned = vflag_d;
		if (rejected_d) begin
			res.status = ST_REJECT;
		end else if (item.last_byte) begin
			if ((phase_d == PH_TRAIL) || ((phase_d == PH_ALTCNT) && (cbytes_d == 2'd0))) begin
				res.status = ST_ACCEPT;
			end else begin
				res.status = ST_REJECT;
			end
		end else begin
			res.status = ST_BUSY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIGCNT;
			accum_q      <= '0;
			cbytes_q     <= '0;
			vflag_q      <= 1'b0;
			total_q      <= '0;
			outer_left_q <= '0;
			inner_left_q <= '0;
			outer_idx_q  <= '0;
			byte_idx_q   <= '0;
			rejected_q   <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q      <= PH_SIGCNT;
				accum_q      <= '0;
				cbytes_q     <= '0;
				vflag_q      <= 1'b0;
				total_q      <= '0;
				outer_left_q <= '0;
				inner_left_q <= '0;
				outer_idx_q  <= '0;
				byte_idx_q   <= '0;
				rejected_q   <= 1'b0;
			end else begin
				phase_q      <= phase_d;
				accum_q      <= accum_d;
				cbytes_q     <= cbytes_d;
				vflag_q      <= vflag_d;
				total_q      <= total_d;
				outer_left_q <= outer_left_d;
				inner_left_q <= inner_left_d;
				outer_idx_q  <= outer_idx_d;
				byte_idx_q   <= byte_idx_d;
				rejected_q   <= rejected_d;
			end
		end
	end

endmodule

### src/transaction_message_parser.sv
// Top level of the transaction message parser: input register, parser core, result register.
//
//   channel   modport   payload       beat
//   stream    sink      in_item_t     one transaction byte with its end mark
//   result    source    out_item_t    tags and status for that byte
//
// One byte per cycle while results drain; a result is registered after the input register.
// The parse state updates once per byte in the core, which sets the rate.
// Reset puts the parser at the signature count with empty input and result registers.
// A stalled result holds; the input register fills if it is empty, then the input stalls.
module transaction_message_parser (
	input logic         clk,
	input logic         arst_n,
	tmp_stream_if.sink  stream,
	tmp_stream_if.source result
);
	import tmp_pkg::*;

	in_item_t  in_s1;
	logic      vld_s1;
	out_item_t core_res;
	out_item_t res_s2;
	logic      vld_s2;
	logic      advance;

	assign advance      = vld_s1 & (~vld_s2 | result.ready);
	assign stream.ready = ~vld_s1 | advance;

	tmp_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (in_s1),
		.res   (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (stream.ready) begin
				vld_s1 <= stream.valid;
			end
			if (advance) begin
				vld_s2 <= 1'b1;
			end else if (result.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			in_s1 <= stream.payload;
		end
		if (advance) begin
			res_s2 <= core_res;
		end
	end

	assign result.valid   = vld_s2;
	assign result.payload = res_s2;

endmodule

### tb/tb_top.sv
// Testbench for the transaction message parser: random byte streams checked against a tag predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tmp_pkg::*;

	typedef enum logic [1:0] {COUNT_MORE, COUNT_DONE, COUNT_BAD} count_step_t;

	class tag_scoreboard;
		logic [4:0]  phase;
		logic [15:0] accum;
		logic [1:0]  count_pos;
		logic        vflag;
		logic [15:0] account_total;
		logic [15:0] outer_left;
		logic [21:0] inner_left;
		logic [15:0] outer_idx;
		logic [15:0] byte_idx;
		logic [1:0]  verdict;
		out_item_t   expected_tags[$];
		int          errors;
		int          checked;

		function new();
			errors = 0;
			checked = 0;
			clear_state();
		endfunction

		function void clear_state();
			phase = SEC_SIGCNT;
			accum = '0;
			count_pos = '0;
			vflag = 1'b0;
			account_total = '0;
			outer_left = '0;
			inner_left = '0;
			outer_idx = '0;
			byte_idx = '0;
			verdict = ST_BUSY;
		endfunction

		function count_step_t feed_count(logic [7:0] b, output logic [15:0] value);
			logic [31:0] merged;
			merged = {16'd0, accum} | ({24'd0, b & 8'h7F} << (7 * count_pos));
			accum = merged[15:0];
			value = '0;
			if (!b[7]) begin
				value = accum;
				accum = '0;
				count_pos = '0;
				return COUNT_DONE;
			end
			if (count_pos == COUNT_LAST_POS) begin
				accum = '0;
				count_pos = '0;
				return COUNT_BAD;
			end
			count_pos++;
			return COUNT_MORE;
		endfunction

		function void start_array(logic [15:0] n, logic [4:0] fill, logic [4:0] empty);
			byte_idx = '0;
			if (n == 0) begin
				phase = empty;
			end else begin
				inner_left = 22'(n);
				phase = fill;
			end
		endfunction

		function bit array_byte();
			byte_idx++;
			inner_left--;
			return inner_left == 0;
		endfunction

		function void after_instructions();
			phase = vflag ? SEC_ALTCNT : SEC_TRAIL;
		endfunction

		function void next_item(logic [4:0] again, logic [4:0] done_phase);
			outer_idx++;
			outer_left--;
			byte_idx = '0;
			if (outer_left == 0) begin
				phase = done_phase;
			end else begin
				phase = again;
				inner_left = (again == SEC_SIG) ? 22'(SIG_BYTES) : 22'(KEY_BYTES);
			end
		endfunction

		function void take_byte(in_item_t it);
			out_item_t   o;
			logic [15:0] n;
			logic [15:0] lim;
			logic [4:0]  ph;
			logic [7:0]  b;
			bit          bad;
			count_step_t step;
			o = '0;
			o.section = SEC_REJECT;
			n = '0;
			bad = 1'b0;
			b = it.data_byte;
			ph = phase;
			if (ph inside {SEC_SIGCNT, SEC_ACCTCNT, SEC_INSTRCNT, SEC_IDXCNT, SEC_DLEN,
					SEC_ALTCNT, SEC_WCNT, SEC_RCNT}) begin
				o.section = ph;
				o.byte_offset = 16'(count_pos);
				if (ph inside {SEC_IDXCNT, SEC_DLEN, SEC_WCNT, SEC_RCNT})
					o.item_index = outer_idx;
				step = feed_count(b, n);
				if (step == COUNT_BAD) begin
					bad = 1'b1;
				end else if (step == COUNT_DONE) begin
					o.count_done = 1'b1;
					o.count_value = n;
					case (ph)
						SEC_SIGCNT: begin
							outer_idx = '0;
							byte_idx = '0;
							if (n == 0) begin
								phase = SEC_VERSION;
							end else begin
								outer_left = n;
								inner_left = 22'(SIG_BYTES);
								phase = SEC_SIG;
							end
						end
						SEC_ACCTCNT: begin
							account_total = n;
							outer_idx = '0;
							byte_idx = '0;
							inner_left = 22'(KEY_BYTES);
							if (n == 0) begin
								phase = SEC_HASH;
							end else begin
								outer_left = n;
								phase = SEC_KEY;
							end
						end
						SEC_INSTRCNT: begin
							outer_idx = '0;
							if (n == 0) begin
								after_instructions();
							end else begin
								outer_left = n;
								phase = SEC_PROG;
							end
						end
						SEC_IDXCNT: start_array(n, SEC_IDX, SEC_DLEN);
						SEC_DLEN: begin
							if (n == 0) begin
								next_item(SEC_PROG, SEC_ALTCNT);
								if (phase == SEC_ALTCNT)
									after_instructions();
							end else begin
								start_array(n, SEC_DATA, SEC_DATA);
							end
						end
						SEC_ALTCNT: begin
							outer_idx = '0;
							byte_idx = '0;
							if (n == 0) begin
								phase = SEC_TRAIL;
							end else begin
								outer_left = n;
								inner_left = 22'(KEY_BYTES);
								phase = SEC_ALTKEY;
							end
						end
						SEC_WCNT: start_array(n, SEC_WIDX, SEC_RCNT);
						default: begin
							if (n == 0)
								next_item(SEC_ALTKEY, SEC_TRAIL);
							else
								start_array(n, SEC_RIDX, SEC_RIDX);
						end
					endcase
				end
			end else begin
				case (ph)
					SEC_SIG: begin
						o.section = SEC_SIG;
						o.item_index = outer_idx;
						o.byte_offset = byte_idx;
						if (array_byte())
							next_item(SEC_SIG, SEC_VERSION);
					end
					SEC_VERSION: begin
						if (b == VERSION_MARK) begin
							o.section = SEC_VERSION;
							vflag = 1'b1;
							phase = SEC_HDR0;
						end else begin
							o.section = SEC_HDR0;
							phase = SEC_HDR1;
						end
					end
					SEC_HDR0: begin
						o.section = SEC_HDR0;
						phase = SEC_HDR1;
					end
					SEC_HDR1: begin
						o.section = SEC_HDR1;
						o.byte_offset = 16'd1;
						phase = SEC_HDR2;
					end
					SEC_HDR2: begin
						o.section = SEC_HDR2;
						o.byte_offset = 16'd2;
						phase = SEC_ACCTCNT;
					end
					SEC_KEY: begin
						o.section = SEC_KEY;
						o.item_index = outer_idx;
						o.byte_offset = byte_idx;
						if (array_byte()) begin
							next_item(SEC_KEY, SEC_HASH);
							if (phase == SEC_HASH)
								inner_left = 22'(KEY_BYTES);
						end
					end
					SEC_HASH: begin
						o.section = SEC_HASH;
						o.byte_offset = byte_idx;
						if (array_byte())
							phase = SEC_INSTRCNT;
					end
					SEC_PROG: begin
						lim = (account_total < 16'(STORED_ACCOUNTS)) ? account_total
							: 16'(STORED_ACCOUNTS);
						o.section = SEC_PROG;
						o.item_index = outer_idx;
						if ({8'd0, b} < lim)
							o.program_ref = PREF_STORED;
						else if ({8'd0, b} < account_total || vflag)
							o.program_ref = PREF_UNKNOWN;
						else
							bad = 1'b1;
						phase = SEC_IDXCNT;
					end
					SEC_IDX: begin
						o.section = SEC_IDX;
						o.item_index = outer_idx;
						o.byte_offset = byte_idx;
						if (array_byte())
							phase = SEC_DLEN;
					end
					SEC_DATA: begin
						o.section = SEC_DATA;
						o.item_index = outer_idx;
						o.byte_offset = byte_idx;
						if (array_byte()) begin
							next_item(SEC_PROG, SEC_ALTCNT);
							if (phase == SEC_ALTCNT)
								after_instructions();
						end
					end
					SEC_ALTKEY: begin
						o.section = SEC_ALTKEY;
						o.item_index = outer_idx;
						o.byte_offset = byte_idx;
						if (array_byte())
							phase = SEC_WCNT;
					end
					SEC_WIDX: begin
						o.section = SEC_WIDX;
						o.item_index = outer_idx;
						o.byte_offset = byte_idx;
						if (array_byte())
							phase = SEC_RCNT;
					end
					SEC_RIDX: begin
						o.section = SEC_RIDX;
						o.item_index = outer_idx;
						o.byte_offset = byte_idx;
						if (array_byte())
							next_item(SEC_ALTKEY, SEC_TRAIL);
					end
					SEC_TRAIL: o.section = SEC_TRAIL;
					default: begin
						o.section = SEC_REJECT;
						bad = 1'b1;
					end
				endcase
			end
			if (bad) begin
				phase = SEC_REJECT;
				verdict = ST_REJECT;
			end
			if (verdict == ST_REJECT)
				o.status = ST_REJECT;
			else if (it.last_byte)
				o.status = (phase == SEC_TRAIL || (phase == SEC_ALTCNT && count_pos == 0))
					? ST_ACCEPT : ST_REJECT;
			else
				o.status = ST_BUSY;
			o.versioned = vflag;
			if (it.last_byte)
				clear_state();
			expected_tags.push_back(o);
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			errors++;
			if (errors <= 40)
				$display("mismatch at result %0d: %s got %0h expected %0h",
					checked, what, got, want);
		endtask

		task compare(string field, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report(field, got, want);
		endtask

		task check_tags(out_item_t got);
			out_item_t want;
			checked++;
			if (expected_tags.size() == 0) begin
				report("result with no byte waiting, section", 16'(got.section), '0);
				return;
			end
			want = expected_tags.pop_front();
			compare("section", 16'(got.section), 16'(want.section));
			compare("item_index", got.item_index, want.item_index);
			compare("byte_offset", got.byte_offset, want.byte_offset);
			compare("count_value", got.count_value, want.count_value);
			compare("count_done", 16'(got.count_done), 16'(want.count_done));
			compare("program_ref", 16'(got.program_ref), 16'(want.program_ref));
			compare("versioned", 16'(got.versioned), 16'(want.versioned));
			compare("status", 16'(got.status), 16'(want.status));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   sent = 0;
	int   send_calm = 0;
	int   take_calm = 0;
	logic [7:0] tx_bytes[$];

	tmp_stream_if #(.payload_t(in_item_t)) stream_if ();
	tmp_stream_if #(.payload_t(out_item_t)) result_if ();

	transaction_message_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_if),
		.result(result_if)
	);

	tag_scoreboard tags = new();

	always #1 clk = ~clk;

	function automatic int pick_gap(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_byte(logic [7:0] b, logic lst);
		int       gap;
		in_item_t it;
		gap = pick_gap(send_calm);
		it.data_byte = b;
		it.last_byte = lst;
		if (gap > 0) begin
			stream_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.payload <= it;
		do @(posedge clk); while (!stream_if.ready);
		tags.take_byte(it);
		sent++;
	endtask

	function automatic void put_random(int n);
		repeat (n) tx_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_count(int value);
		int len;
		len = value < 128 ? 1 : (value < 16384 ? 2 : 3);
		if (len < 3 && $urandom_range(0, 4) == 0)
			len = $urandom_range(len, 3);
		for (int i = 0; i < len; i++)
			tx_bytes.push_back(8'(((value >> (7 * i)) & 'h7F) | (i < len - 1 ? 'h80 : 0)));
	endfunction

	function automatic void build_transaction();
		int versioned;
		int sigs;
		int accounts;
		int instrs;
		int lookups;
		int n;
		tx_bytes.delete();
		versioned = $urandom_range(0, 1);
		sigs = ($urandom_range(0, 5) == 0) ? 1 : 0;
		put_count(sigs);
		put_random(64 * sigs);
		if (versioned)
			tx_bytes.push_back(VERSION_MARK);
		n = $urandom_range(0, 255);
		if (!versioned && n == VERSION_MARK)
			n = 0;
		tx_bytes.push_back(8'(n));
		put_random(2);
		accounts = ($urandom_range(0, 24) == 0) ? $urandom_range(16, 18) : $urandom_range(0, 2);
		put_count(accounts);
		put_random(32 * accounts + 32);
		instrs = $urandom_range(0, 3);
		if (accounts == 0 && !versioned && $urandom_range(0, 3) != 0)
			instrs = 0;
		put_count(instrs);
		repeat (instrs) begin
			if (accounts > 0 && $urandom_range(0, 4) != 0)
				tx_bytes.push_back(8'($urandom_range(0, accounts - 1)));
			else
				put_random(1);
			n = $urandom_range(0, 3);
			put_count(n);
			put_random(n);
			n = $urandom_range(0, 4);
			put_count(n);
			put_random(n);
		end
		if (versioned && $urandom_range(0, 3) != 0) begin
			lookups = $urandom_range(0, 2);
			put_count(lookups);
			repeat (lookups) begin
				put_random(32);
				repeat (2) begin
					n = $urandom_range(0, 2);
					put_count(n);
					put_random(n);
				end
			end
		end
		if ($urandom_range(0, 3) == 0)
			put_random($urandom_range(1, 3));
	endfunction

	initial begin
		int kind;
		int cut;
		arst_n <= 1'b0;
		stream_if.valid <= 1'b0;
		stream_if.payload <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(VERSION_MARK, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h00, 1'b1);

		while (sent < 1750) begin
			kind = $urandom_range(0, 9);
			if (kind == 9) begin
				tx_bytes.delete();
				put_random($urandom_range(1, 8));
			end else begin
				build_transaction();
				if (kind == 7) begin
					cut = $urandom_range(1, tx_bytes.size());
					while (tx_bytes.size() > cut)
						void'(tx_bytes.pop_back());
				end else if (kind == 8) begin
					tx_bytes[$urandom_range(0, tx_bytes.size() - 1)] = 8'($urandom_range(0, 255));
				end
			end
			foreach (tx_bytes[i])
				send_byte(tx_bytes[i], i == tx_bytes.size() - 1);
		end
		stream_if.valid <= 1'b0;

		while (tags.expected_tags.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tags.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// The receiver stops once for a long stretch so that the parser backs up into its input.
	initial begin
		int stall;
		bit held;
		held = 1'b0;
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && tags.checked >= 400) begin
				held = 1'b1;
				result_if.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			stall = pick_gap(take_calm);
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			tags.check_tags(result_if.payload);
		end
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
